>>> rtl/rgtg_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, register indexes and constant roots for the radial glow generator.
// No dependencies.
package rgtg_pkg;

  localparam int COORD_BITS   = 12;
  localparam int MAX_CHANNELS = 4;
  localparam int SIZE_W       = 13;
  localparam int EXPO_W       = 16;
  localparam int DISC_W       = 16;
  localparam int CHAN_W       = 3;
  localparam int SAMPLE_W     = 17;
  localparam int CIDX_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // Datapath widths
  localparam int DIFF_W   = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
  localparam int QUO_W    = DIFF_W + 15;
  localparam int ROOT_W   = QUO_W + 1;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STG  = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int SQ_STEPS = 4;
  localparam int SQ_STG   = (ROOT_W + SQ_STEPS - 1) / SQ_STEPS;
  localparam int POW_BITS = 16;
  localparam int ACC_W    = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT  = 3'd6;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [CIDX_W-1:0]   channel_index;
    logic                last_of_texel;
  } out_item_t;

  // Floor square root, elaboration only
  function automatic logic [63:0] isqrt_const(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] b;
    rem = v;
    r   = '0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q30, by repeated square roots
  function automatic logic [ACC_W-1:0] root_const(input int k);
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int i = 1; i <= POW_BITS; i++) begin
      if (i <= k) r = isqrt_const(r << 30);
    end
    return r[ACC_W-1:0];
  endfunction

endpackage

>>> rtl/radial_glow_texel_generator.sv
`timescale 1ns / 1ps
// Top level of the radial glow texel generator: config registers, offset, distance,
// falloff and power pipeline, output beat serializer. Uses rgtg_pkg, rgtg_divider, rgtg_sqrt.
//
// A texel is taken on start while busy is low and its samples come out at the pipeline end,
// one beat per cycle on out_valid, channel_count beats per texel (1 to 4), the last beat
// flagged. The output serializer sets the rate: a new texel can enter every cycle when
// channel_count is 1, otherwise not before the last beat of the texel before it; busy is high
// while the serializer still has beats of the current texel to send, and the whole pipeline
// holds. Results are presented for one cycle each and the receiver cannot stall them.
module radial_glow_texel_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  rgtg_pkg::in_item_t          in_data,
  output logic                        out_valid,
  output rgtg_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [rgtg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgtg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rgtg_pkg::*;

  localparam int LAT = DIV_STG + SQ_STG + 23;

  // configuration registers
  logic [SIZE_W-1:0] width_r, height_r;
  logic [EXPO_W-1:0] expo_r;
  logic [DISC_W-1:0] disc_r;
  logic              curve_r, format_r;
  logic [CHAN_W-1:0] chan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(256);
      height_r <= SIZE_W'(256);
      expo_r   <= EXPO_W'(256);
      disc_r   <= '0;
      curve_r  <= 1'b0;
      chan_r   <= CHAN_W'(1);
      format_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:   width_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_HEIGHT:  height_r <= cfg_wdata[SIZE_W-1:0];
        CFG_EXPO:    expo_r   <= cfg_wdata[EXPO_W-1:0];
        CFG_DISC:    disc_r   <= cfg_wdata[DISC_W-1:0];
        CFG_CURVE:   curve_r  <= cfg_wdata[0];
        CFG_CHANNEL: chan_r   <= cfg_wdata[CHAN_W-1:0];
        CFG_FORMAT:  format_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline enable and valid chain
  logic           en;
  logic [LAT-1:0] vld_r;
  logic           em_active_r;
  logic [CIDX_W-1:0] em_idx_r, em_lastidx_r;
  logic [SAMPLE_W-1:0] em_sample_r;

  assign en   = !em_active_r || (em_idx_r == em_lastidx_r);
  assign busy = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], start};
  end

  // input stage
  in_item_t in_r;
  always_ff @(posedge clk) begin
    if (en) in_r <= in_data;
  end

  // centred offset numerators: |2c+1-s| * 2^15 + s/2
  logic [SIZE_W-1:0] sw, sh;
  logic [DIFF_W-1:0] twox, twoy, diffx, diffy;
  logic [QUO_W-1:0]  numx, numy, ax, ay;

  assign sw   = (width_r == '0) ? SIZE_W'(1) : width_r;
  assign sh   = (height_r == '0) ? SIZE_W'(1) : height_r;
  assign twox = DIFF_W'({in_r.column, 1'b1});
  assign twoy = DIFF_W'({in_r.row, 1'b1});
  assign diffx = (twox >= DIFF_W'(sw)) ? twox - DIFF_W'(sw) : DIFF_W'(sw) - twox;
  assign diffy = (twoy >= DIFF_W'(sh)) ? twoy - DIFF_W'(sh) : DIFF_W'(sh) - twoy;
  assign numx = QUO_W'({diffx, 15'd0}) | QUO_W'(sw >> 1);
  assign numy = QUO_W'({diffy, 15'd0}) | QUO_W'(sh >> 1);

  rgtg_divider #(.NUM_W(QUO_W), .DEN_W(SIZE_W), .STEPS(DIV_STEPS)) u_divx (
    .clk(clk), .en(en), .num_i(numx), .den_i(sw), .quo_o(ax)
  );
  rgtg_divider #(.NUM_W(QUO_W), .DEN_W(SIZE_W), .STEPS(DIV_STEPS)) u_divy (
    .clk(clk), .en(en), .num_i(numy), .den_i(sh), .quo_o(ay)
  );

  // squares, then their sum
  logic [2*QUO_W-1:0] sqx_r, sqy_r;
  logic [RAD_W-1:0]   sum_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= ax * ax;
      sqy_r <= ay * ay;
      sum_r <= RAD_W'(sqx_r) + RAD_W'(sqy_r);
    end
  end

  logic [ROOT_W-1:0] radius;
  rgtg_sqrt #(.ROOT_W(ROOT_W), .STEPS(SQ_STEPS)) u_sqrt (
    .clk(clk), .en(en), .rad_i(sum_r), .root_o(radius)
  );

  // distance beyond the disc, times exposure
  logic [ROOT_W-1:0]        ex_r;
  logic [ROOT_W+EXPO_W-1:0] prod;
  logic                     sat_r;
  logic [POW_BITS-1:0]      tf_r;

  assign prod = ex_r * expo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r  <= (radius > ROOT_W'(disc_r)) ? radius - ROOT_W'(disc_r) : '0;
      sat_r <= |prod[ROOT_W+EXPO_W-1:24];
      tf_r  <= prod[23:8];
    end
  end

  // 2^t: one rounded root multiply per fraction bit
  logic [ACC_W-1:0]    acc_r [POW_BITS];
  logic [POW_BITS-1:0] tfp_r [POW_BITS];
  logic                satp_r [POW_BITS];

  for (genvar k = 1; k <= POW_BITS; k++) begin : g_pow
    localparam logic [ACC_W-1:0] RK = root_const(k);
    logic [ACC_W-1:0]    acc_in;
    logic [POW_BITS-1:0] tf_in;
    logic                sat_in;
    logic [2*ACC_W-1:0]  mul;
    logic [2*ACC_W-1:0]  mul_rnd;

    if (k == 1) begin : g_first
      assign acc_in = ACC_W'(1) << 30;
      assign tf_in  = tf_r;
      assign sat_in = sat_r;
    end else begin : g_next
      assign acc_in = acc_r[k-2];
      assign tf_in  = tfp_r[k-2];
      assign sat_in = satp_r[k-2];
    end

    assign mul     = acc_in * RK;
    assign mul_rnd = mul + (64'd1 << 29);

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k-1]  <= tf_in[POW_BITS-k] ? mul_rnd[61:30] : acc_in;
        tfp_r[k-1]  <= tf_in;
        satp_r[k-1] <= sat_in;
      end
    end
  end

  // p in Q16, and (p + 524293) / 10 by reciprocal multiply
  logic [ACC_W:0]  acc_rnd;
  logic [18:0]     praw;
  logic [17:0]     p, p_r;
  logic [19:0]     xsum;
  logic [39:0]     xmul;
  logic [16:0]     q10_r;

  assign acc_rnd = {1'b0, acc_r[POW_BITS-1]} + (ACC_W+1)'(8192);
  assign praw    = acc_rnd[32:14];
  assign p       = (satp_r[POW_BITS-1] || praw > 19'd131072) ? 18'd131072 : praw[17:0];
  assign xsum    = 20'(p) + 20'd524293;
  assign xmul    = xsum * 20'd838861;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= p;
      q10_r <= xmul[39:23];
    end
  end

  // curve and output format
  logic [17:0]         inten;
  logic [26:0]         bytev;
  logic [SAMPLE_W-1:0] sample_r;

  assign inten = curve_r ? 18'd131072 - p_r : 18'(q10_r);
  assign bytev = 27'(inten) * 27'd255 + 27'd32768;

  always_ff @(posedge clk) begin
    if (en) sample_r <= format_r ? inten[16:0] : 17'(bytev[26:16]);
  end

  // output beat serializer
  logic [CIDX_W-1:0] last_idx;
  always_comb begin
    if (chan_r == '0)                          last_idx = '0;
    else if (chan_r > CHAN_W'(MAX_CHANNELS))   last_idx = CIDX_W'(MAX_CHANNELS - 1);
    else                                       last_idx = CIDX_W'(chan_r - CHAN_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_active_r <= 1'b0;
      em_idx_r    <= '0;
    end else if (en) begin
      em_active_r <= vld_r[LAT-1];
      em_idx_r    <= '0;
    end else if (em_active_r) begin
      em_idx_r <= em_idx_r + CIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      em_sample_r  <= sample_r;
      em_lastidx_r <= last_idx;
    end
  end

  assign out_valid              = em_active_r;
  assign out_data.sample        = em_sample_r;
  assign out_data.channel_index = em_idx_r;
  assign out_data.last_of_texel = (em_idx_r == em_lastidx_r);

endmodule

>>> rtl/rgtg_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, a few quotient bits per stage.
// Depends on nothing; widths come from the instantiating module.
module rgtg_divider #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 13,
  parameter int STEPS = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  localparam int NSTG = (NUM_W + STEPS - 1) / STEPS;

  logic [DEN_W-1:0] rem_r [NSTG];
  logic [DEN_W-1:0] den_r [NSTG];
  logic [NUM_W-1:0] num_r [NSTG];
  logic [NUM_W-1:0] quo_r [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    logic [DEN_W-1:0] rem_in, den_in, rem_nxt;
    logic [NUM_W-1:0] num_in, quo_in, num_nxt, quo_nxt;
    logic [DEN_W:0]   sh;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_i;
      assign num_in = num_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign num_in = num_r[g-1];
      assign quo_in = quo_r[g-1];
    end

    // a few shift-compare-subtract steps
    always_comb begin
      rem_nxt = rem_in;
      num_nxt = num_in;
      quo_nxt = quo_in;
      sh      = '0;
      for (int j = 0; j < STEPS; j++) begin
        if (g * STEPS + j < NUM_W) begin
          sh      = {rem_nxt, num_nxt[NUM_W-1]};
          num_nxt = {num_nxt[NUM_W-2:0], 1'b0};
          if (sh >= {1'b0, den_in}) begin
            rem_nxt = DEN_W'(sh - {1'b0, den_in});
            quo_nxt = {quo_nxt[NUM_W-2:0], 1'b1};
          end else begin
            rem_nxt = sh[DEN_W-1:0];
            quo_nxt = {quo_nxt[NUM_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        den_r[g] <= den_in;
        num_r[g] <= num_nxt;
        quo_r[g] <= quo_nxt;
      end
    end
  end

  assign quo_o = quo_r[NSTG-1];

endmodule

>>> rtl/rgtg_sqrt.sv
`timescale 1ns / 1ps
// Pipelined digit-by-digit floor square root, a few root bits per stage.
// Depends on nothing; widths come from the instantiating module.
module rgtg_sqrt #(
  parameter int ROOT_W = 29,
  parameter int STEPS  = 4
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2*ROOT_W-1:0] rad_i,
  output logic [ROOT_W-1:0]   root_o
);

  localparam int NSTG = (ROOT_W + STEPS - 1) / STEPS;

  logic [ROOT_W+1:0]   rem_r  [NSTG];
  logic [2*ROOT_W-1:0] rad_r  [NSTG];
  logic [ROOT_W-1:0]   root_r [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    logic [ROOT_W+1:0]   rem_in, rem_nxt, rs, trial;
    logic [2*ROOT_W-1:0] rad_in, rad_nxt;
    logic [ROOT_W-1:0]   root_in, root_nxt;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign rad_in  = rad_r[g-1];
      assign root_in = root_r[g-1];
    end

    // bring down two radicand bits, try a one digit
    always_comb begin
      rem_nxt  = rem_in;
      rad_nxt  = rad_in;
      root_nxt = root_in;
      rs       = '0;
      trial    = '0;
      for (int j = 0; j < STEPS; j++) begin
        if (g * STEPS + j < ROOT_W) begin
          rs      = {rem_nxt[ROOT_W-1:0], rad_nxt[2*ROOT_W-1 -: 2]};
          rad_nxt = {rad_nxt[2*ROOT_W-3:0], 2'b00};
          trial   = {root_nxt, 2'b01};
          if (rs >= trial) begin
            rem_nxt  = rs - trial;
            root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
          end else begin
            rem_nxt  = rs;
            root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        rad_r[g]  <= rad_nxt;
        root_r[g] <= root_nxt;
      end
    end
  end

  assign root_o = root_r[NSTG-1];

endmodule

>>> rtl/rgtg_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the radial glow generator and the bind that attaches them.
// Uses rgtg_pkg; binds to radial_glow_texel_generator.
module rgtg_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        busy,
  input logic                        out_valid,
  input rgtg_pkg::out_item_t         out_data
);
  import rgtg_pkg::*;

  // beats of one texel follow back to back
  a_beats_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_texel |=> out_valid)
    else $error("texel beats interrupted");

  // channel index counts up within a texel
  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_texel |=>
      out_data.channel_index == $past(out_data.channel_index) + 2'd1)
    else $error("channel index did not advance");

  // all channels of a texel carry the same sample
  a_sample_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_texel |=> $stable(out_data.sample))
    else $error("sample changed within a texel");

  // no new texel while beats remain
  a_busy_mid_texel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_texel |-> busy)
    else $error("busy low with beats pending");

  // a texel that follows an idle cycle starts at channel zero
  a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> out_data.channel_index == '0)
    else $error("texel did not start at channel zero");

endmodule

bind radial_glow_texel_generator rgtg_checker u_rgtg_checker (.*);
